// ===== hw/rtl/efba_pkg.sv =====
// ----------------------------------------------------------------------------
// efba_pkg
// Shared constants and types of the exact-fit block allocator.
// ----------------------------------------------------------------------------
package efba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 32;
    localparam int NEED_W     = 33;
    localparam int BYTES_W    = 34;
    localparam int LIMIT_W    = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 32'h0100_0000;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_LIMIT     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_BLOCK = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE  = 1'b0,
        REG_LIMIT = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    // table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [NEED_W-1:0] bytes;
        logic              in_use;
    } t_entry;

    // controller -> table memory
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_entry           wr_data;
    } t_mem_req;

endpackage

// ===== hw/rtl/efba_table.sv =====
// ----------------------------------------------------------------------------
// efba_table
// Block table memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module efba_table (
    input  logic                i_clk,
    input  efba_pkg::t_mem_req  i_req,
    output efba_pkg::t_entry    o_rd_data
);

    efba_pkg::t_entry r_mem [efba_pkg::MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_idx];
        end
    end

endmodule

// ===== hw/rtl/efba_ctrl.sv =====
// ----------------------------------------------------------------------------
// efba_ctrl
// Request sequencer: walks the table, then updates it and the counters.
// ----------------------------------------------------------------------------
module efba_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [efba_pkg::ADDR_W-1:0]         i_base,
    input  logic [efba_pkg::LIMIT_W-1:0]        i_limit,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic [efba_pkg::SIZE_W-1:0]         i_request_size,
    input  logic [efba_pkg::SIZE_W-1:0]         i_padding,
    input  logic                                i_want_writable,
    input  logic                                i_want_user,
    input  logic                                i_page_request,
    input  logic [efba_pkg::ADDR_W-1:0]         i_free_address,
    output efba_pkg::t_mem_req                  o_mem,
    input  efba_pkg::t_entry                    i_rd_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0]                          o_status,
    output logic [efba_pkg::ADDR_W-1:0]         o_block_address,
    output logic                                o_map_request,
    output logic                                o_map_writable,
    output logic                                o_map_user,
    output logic [efba_pkg::CNT_W-1:0]          o_block_count
);

    localparam int IW = efba_pkg::IDX_W;
    localparam int CW = efba_pkg::CNT_W;
    localparam int AW = efba_pkg::ADDR_W;
    localparam int NW = efba_pkg::NEED_W;
    localparam int BW = efba_pkg::BYTES_W;

    efba_pkg::t_state r_state, n_state;

    logic          r_cmd, r_wr, r_usr;
    logic [NW-1:0] r_need;
    logic [AW-1:0] r_faddr;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count;
    logic [BW-1:0] r_bytes;
    logic [AW-1:0] r_offset;

    logic          r_ovalid;
    logic [2:0]    r_status;
    logic [AW-1:0] r_addr;
    logic          r_mreq, r_mwr, r_musr;

    logic          hit;
    logic          walk_end;
    logic [BW:0]   sum;
    logic          early;
    logic [2:0]    early_st;
    logic          done_go;

    assign hit = r_cmd ? (i_rd_data.start == r_faddr)
                       : (i_rd_data.bytes == r_need && !i_rd_data.in_use);
    assign walk_end = (r_idx >= r_count);
    assign sum = {1'b0, r_bytes} + (BW+1)'(r_need);

    assign early = !i_command && (i_page_request || i_request_size == '0
                                  || r_bytes > BW'(i_limit));
    assign early_st = (i_page_request || i_request_size == '0)
                      ? efba_pkg::ST_REJECTED : efba_pkg::ST_LIMIT;

    assign o_ready = (r_state == efba_pkg::S_IDLE) && (!r_ovalid || i_ready);
    assign done_go = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            efba_pkg::S_IDLE: begin
                if (i_valid && o_ready && !early) begin
                    n_state = efba_pkg::S_READ;
                    n_idx   = '0;
                end
            end
            efba_pkg::S_READ: begin
                n_state = walk_end ? efba_pkg::S_DONE : efba_pkg::S_CHECK;
            end
            efba_pkg::S_CHECK: begin
                if (hit) begin
                    n_state = efba_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = efba_pkg::S_READ;
                end
            end
            efba_pkg::S_DONE: begin
                if (done_go) begin
                    n_state = efba_pkg::S_IDLE;
                end
            end
            default: n_state = efba_pkg::S_IDLE;
        endcase
    end

    // memory requests
    always_comb begin
        o_mem = '0;
        o_mem.rd_idx = r_idx[IW-1:0];
        o_mem.rd_en  = (r_state == efba_pkg::S_READ) && !walk_end;
        o_mem.wr_idx = r_idx[IW-1:0];
        if (r_state == efba_pkg::S_DONE && done_go && !walk_end) begin
            o_mem.wr_en   = 1'b1;
            o_mem.wr_data = i_rd_data;
            o_mem.wr_data.in_use = !r_cmd;
        end else if (r_state == efba_pkg::S_DONE && done_go && !r_cmd
                     && r_count < CW'(efba_pkg::MAX_BLOCKS)) begin
            o_mem.wr_en         = 1'b1;
            o_mem.wr_data.start = i_base + r_offset;
            o_mem.wr_data.bytes = r_need;
            o_mem.wr_data.in_use = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= efba_pkg::S_IDLE;
            r_idx    <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_offset <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == efba_pkg::S_IDLE && i_valid && o_ready && early) begin
                r_ovalid <= 1'b1;
                r_status <= early_st;
                r_addr   <= '0;
                r_mreq   <= 1'b0;
                r_mwr    <= 1'b0;
                r_musr   <= 1'b0;
            end
            if (r_state == efba_pkg::S_DONE && done_go) begin
                r_ovalid <= 1'b1;
                r_status <= efba_pkg::ST_OK;
                r_addr   <= '0;
                r_mreq   <= 1'b0;
                r_mwr    <= 1'b0;
                r_musr   <= 1'b0;
                if (r_cmd) begin
                    if (walk_end) begin
                        r_status <= efba_pkg::ST_NOT_BLOCK;
                    end else if (i_rd_data.in_use) begin
                        r_bytes <= (r_bytes > BW'(i_rd_data.bytes))
                                   ? r_bytes - BW'(i_rd_data.bytes) : '0;
                    end
                end else if (!walk_end) begin
                    r_addr  <= i_rd_data.start;
                    r_mreq  <= 1'b1;
                    r_mwr   <= r_wr;
                    r_musr  <= r_usr;
                    r_bytes <= sum[BW] ? efba_pkg::BYTES_MAX : sum[BW-1:0];
                end else if (r_count >= CW'(efba_pkg::MAX_BLOCKS)) begin
                    r_status <= efba_pkg::ST_FULL;
                end else begin
                    r_addr   <= i_base + r_offset;
                    r_mreq   <= 1'b1;
                    r_mwr    <= r_wr;
                    r_musr   <= r_usr;
                    r_bytes  <= sum[BW] ? efba_pkg::BYTES_MAX : sum[BW-1:0];
                    r_offset <= r_offset + AW'(r_need);
                    r_count  <= r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == efba_pkg::S_IDLE && i_valid && o_ready) begin
            r_cmd   <= i_command;
            r_wr    <= i_want_writable;
            r_usr   <= i_want_user;
            r_need  <= NW'(i_request_size) + NW'(i_padding);
            r_faddr <= i_free_address;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_block_address = r_addr;
    assign o_map_request   = r_mreq;
    assign o_map_writable  = r_mwr;
    assign o_map_user      = r_musr;
    assign o_block_count   = r_count;

endmodule

// ===== hw/rtl/exact_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// exact_fit_block_allocator_unit
// Exact-fit allocator over a linear region with a 256-entry block table.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries allocate or free transactions; the
// output channel (o_valid/i_ready) returns one status transaction for each.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 region base, 1 region limit) at once; write only while idle.
// An allocate walks the table from entry 0, reading each entry and then
// comparing it, until the first free block of exactly the needed size
// or the end of the table. A free walks until the first entry whose start
// matches. A new transaction is accepted only after the previous one has
// finished; rejected or over-limit allocations are answered without a walk.
// The result waits in an output register; a stalled receiver keeps o_ready
// low until the result is taken.
// Reset (synchronous, i_rst_n low) empties the table, clears the byte
// count and the end offset, and restores the configuration defaults.
// ----------------------------------------------------------------------------
module exact_fit_block_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [efba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [efba_pkg::ADDR_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic [efba_pkg::SIZE_W-1:0]         i_request_size,
    input  logic [efba_pkg::SIZE_W-1:0]         i_padding,
    input  logic                                i_want_writable,
    input  logic                                i_want_user,
    input  logic                                i_page_request,
    input  logic [efba_pkg::ADDR_W-1:0]         i_free_address,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0]                          o_status,
    output logic [efba_pkg::ADDR_W-1:0]         o_block_address,
    output logic                                o_map_request,
    output logic                                o_map_writable,
    output logic                                o_map_user
);

    logic [efba_pkg::ADDR_W-1:0]  r_base;
    logic [efba_pkg::LIMIT_W-1:0] r_limit;
    efba_pkg::t_mem_req           mem_req;
    efba_pkg::t_entry             rd_data;
    logic [efba_pkg::CNT_W-1:0]   block_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= efba_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (efba_pkg::t_reg'(i_cfg_idx))
                efba_pkg::REG_BASE:  r_base  <= i_cfg_data;
                efba_pkg::REG_LIMIT: r_limit <= i_cfg_data[efba_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    efba_table u_table (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    efba_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_base          (r_base),
        .i_limit         (r_limit),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_request_size  (i_request_size),
        .i_padding       (i_padding),
        .i_want_writable (i_want_writable),
        .i_want_user     (i_want_user),
        .i_page_request  (i_page_request),
        .i_free_address  (i_free_address),
        .o_mem           (mem_req),
        .i_rd_data       (rd_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_map_request   (o_map_request),
        .o_map_writable  (o_map_writable),
        .o_map_user      (o_map_user),
        .o_block_count   (block_count)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        block_count <= efba_pkg::CNT_W'(efba_pkg::MAX_BLOCKS))
        else $error("block count beyond table depth");

    a_map_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_map_request |-> o_status == efba_pkg::ST_OK)
        else $error("mapping requested on failed transaction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(block_count) |-> block_count == $past(block_count) + 1'b1)
        else $error("block count moved by other than one");

endmodule

// ===== tb/efba_checker.sv =====
// ----------------------------------------------------------------------------
// efba_checker
// Watches both channels and the configuration port of the exact-fit block
// allocator, predicts each status transaction from a private copy of the
// block table, and compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module efba_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [efba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [efba_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_ready_in,
    input  logic                           i_command,
    input  logic [efba_pkg::SIZE_W-1:0]    i_request_size,
    input  logic [efba_pkg::SIZE_W-1:0]    i_padding,
    input  logic                           i_want_writable,
    input  logic                           i_want_user,
    input  logic                           i_page_request,
    input  logic [efba_pkg::ADDR_W-1:0]    i_free_address,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [2:0]                     i_status,
    input  logic [efba_pkg::ADDR_W-1:0]    i_block_address,
    input  logic                           i_map_request,
    input  logic                           i_map_writable,
    input  logic                           i_map_user,
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = efba_pkg::ADDR_W;
    localparam int SW = efba_pkg::SIZE_W;
    localparam int NW = efba_pkg::NEED_W;
    localparam int BW = efba_pkg::BYTES_W;
    localparam int LW = efba_pkg::LIMIT_W;

    typedef struct packed {
        efba_pkg::t_status status;
        logic [AW-1:0]     addr;
        logic              map;
        logic              wr;
        logic              usr;
    } t_grant;

    logic [AW-1:0] base_q;
    logic [LW-1:0] limit_q;
    logic [AW-1:0] tbl_start [efba_pkg::MAX_BLOCKS];
    logic [NW-1:0] tbl_bytes [efba_pkg::MAX_BLOCKS];
    logic          tbl_used  [efba_pkg::MAX_BLOCKS];
    int            n_blocks;
    logic [BW-1:0] used_bytes;
    logic [AW-1:0] end_offset;
    t_grant        expected_grants[$];

    function automatic t_grant allocate(logic [SW-1:0] sz, logic [SW-1:0] pad,
                                        logic wr, logic usr, logic page);
        t_grant        g;
        logic [NW-1:0] need;
        logic [BW:0]   sum;
        int            k;
        g    = '0;
        need = NW'(sz) + NW'(pad);
        if (page || sz == 0) begin
            g.status = efba_pkg::ST_REJECTED;
            return g;
        end
        if (used_bytes > BW'(limit_q)) begin
            g.status = efba_pkg::ST_LIMIT;
            return g;
        end
        k = 0;
        while (k < n_blocks && !(tbl_bytes[k] == need && !tbl_used[k])) k++;
        if (k == n_blocks) begin
            if (n_blocks >= efba_pkg::MAX_BLOCKS) begin
                g.status = efba_pkg::ST_FULL;
                return g;
            end
            tbl_start[k] = base_q + end_offset;
            tbl_bytes[k] = need;
            n_blocks++;
            end_offset = end_offset + AW'(need);
        end
        tbl_used[k] = 1'b1;
        sum = (BW+1)'(used_bytes) + (BW+1)'(need);
        used_bytes = sum > (BW+1)'(efba_pkg::BYTES_MAX) ? efba_pkg::BYTES_MAX
                                                         : sum[BW-1:0];
        g.status = efba_pkg::ST_OK;
        g.addr   = tbl_start[k];
        g.map    = 1'b1;
        g.wr     = wr;
        g.usr    = usr;
        return g;
    endfunction

    function automatic t_grant release_block(logic [AW-1:0] addr);
        t_grant g;
        g = '0;
        g.status = efba_pkg::ST_NOT_BLOCK;
        for (int k = 0; k < n_blocks; k++) begin
            if (tbl_start[k] == addr) begin
                if (tbl_used[k]) begin
                    tbl_used[k] = 1'b0;
                    used_bytes = used_bytes > BW'(tbl_bytes[k]) ?
                                 used_bytes - BW'(tbl_bytes[k]) : '0;
                end
                g.status = efba_pkg::ST_OK;
                return g;
            end
        end
        return g;
    endfunction

    assign o_pending = expected_grants.size();

    always @(posedge i_clk) begin
        t_grant g;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            base_q     <= '0;
            limit_q    <= efba_pkg::LIMIT_RST;
            n_blocks   <= 0;
            used_bytes <= '0;
            end_offset <= '0;
            o_errors   <= 0;
            expected_grants.delete();
        end else begin
            if (i_cfg_we) begin
                if (efba_pkg::t_reg'(i_cfg_idx) == efba_pkg::REG_BASE) base_q <= i_cfg_data;
                else limit_q <= i_cfg_data[LW-1:0];
            end
            if (i_valid && i_ready_in) begin
                g = i_command ? release_block(i_free_address)
                              : allocate(i_request_size, i_padding, i_want_writable,
                                         i_want_user, i_page_request);
                expected_grants.push_back(g);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_grants.size() == 0) begin
                    $error("unexpected transaction, status %0d", i_status);
                    errs++;
                end else begin
                    g = expected_grants.pop_front();
                    if (i_status !== g.status) begin
                        $error("status: expected %0d, got %0d", g.status, i_status);
                        errs++;
                    end
                    if (i_block_address !== g.addr) begin
                        $error("block_address: expected %h, got %h", g.addr, i_block_address);
                        errs++;
                    end
                    if (i_map_request !== g.map) begin
                        $error("map_request: expected %b, got %b", g.map, i_map_request);
                        errs++;
                    end
                    if (i_map_writable !== g.wr) begin
                        $error("map_writable: expected %b, got %b", g.wr, i_map_writable);
                        errs++;
                    end
                    if (i_map_user !== g.usr) begin
                        $error("map_user: expected %b, got %b", g.usr, i_map_user);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                o_errors <= o_errors + errs;
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free transactions with random gaps and stalls into
// the exact-fit block allocator across several region settings; a checker
// beside the block predicts and compares every status transaction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = efba_pkg::ADDR_W;
    localparam int SW = efba_pkg::SIZE_W;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [efba_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [AW-1:0]                  i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic                           i_command = 1'b0;
    logic [SW-1:0]                  i_request_size = '0;
    logic [SW-1:0]                  i_padding = '0;
    logic                           i_want_writable = 1'b0;
    logic                           i_want_user = 1'b0;
    logic                           i_page_request = 1'b0;
    logic [AW-1:0]                  i_free_address = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [2:0]                     o_status;
    logic [AW-1:0]                  o_block_address;
    logic                           o_map_request;
    logic                           o_map_writable;
    logic                           o_map_user;
    int                             errors;
    int                             pending;
    bit                             stim_done = 1'b0;
    logic [AW-1:0]                  granted_addrs[$];

    exact_fit_block_allocator_unit DUT (.*);

    efba_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_command, .i_request_size, .i_padding,
        .i_want_writable, .i_want_user, .i_page_request, .i_free_address,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_status(o_status),
        .i_block_address(o_block_address), .i_map_request(o_map_request),
        .i_map_writable(o_map_writable), .i_map_user(o_map_user),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // collect granted addresses so frees mostly hit real blocks
    always @(posedge i_clk) begin
        if (o_valid && i_ready && o_map_request) begin
            granted_addrs.push_back(o_block_address);
            if (granted_addrs.size() > 64) void'(granted_addrs.pop_front());
        end
    end

    initial begin
        int stall;
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            repeat (stall) @(posedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            i_ready <= 1'b0;
        end
    end

    task automatic write_reg(efba_pkg::t_reg idx, logic [AW-1:0] val);
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(logic cmd, logic [SW-1:0] sz, logic [SW-1:0] pad,
                        logic wr, logic usr, logic page, logic [AW-1:0] addr,
                        bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        repeat (gap) @(posedge i_clk);
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_request_size  <= sz;
        i_padding       <= pad;
        i_want_writable <= wr;
        i_want_user     <= usr;
        i_page_request  <= page;
        i_free_address  <= addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic alloc(logic [SW-1:0] sz, logic [SW-1:0] pad, bit ng = 0);
        send(1'b0, sz, pad, 1'($urandom), 1'($urandom), 1'b0, 48'($urandom), ng);
    endtask

    task automatic free_at(logic [AW-1:0] a);
        send(1'b1, 32'($urandom), 32'($urandom), 1'($urandom), 1'($urandom),
             1'($urandom), a);
    endtask

    task automatic random_phase(int n, bit wild);
        logic [SW-1:0] sz;
        for (int i = 0; i < n; i++) begin
            sz = wild ? $urandom : $urandom_range(1, 8) * 16;
            case ($urandom_range(0, 9))
                0: send(1'b0, $urandom_range(0, 1) ? 32'd0 : sz, $urandom,
                        1'($urandom), 1'($urandom), 1'($urandom), 48'($urandom));
                1, 2, 3: begin
                    if (granted_addrs.size() != 0 && $urandom_range(0, 5) != 0)
                        free_at(granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]);
                    else
                        free_at(48'({$urandom, $urandom}));
                end
                default: alloc(sz, wild ? $urandom : 32'($urandom_range(0, 1) * 16),
                               i < 40);
            endcase
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, rejects, busy match, reuse, double free, bogus free
        send(1'b0, 32'd0, 32'd5, 1'b1, 1'b1, 1'b0, '0);
        send(1'b0, 32'd8, 32'd0, 1'b1, 1'b0, 1'b1, '0);
        alloc(32'd16, 32'd0);
        alloc(32'd16, 32'd0);
        alloc(32'd8, 32'd8);
        free_at(48'd16);
        alloc(32'd16, 32'd0);
        free_at(48'd16);
        free_at(48'd16);
        free_at(48'hFFFF_FFFF_FFFF);
        free_at(48'd17);
        alloc(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        alloc(32'd1, 32'd0);
        alloc(32'd4, 32'd4);
        free_at(48'd0);
        free_at(48'd32);
        write_reg(efba_pkg::REG_LIMIT, 48'd0);
        write_reg(efba_pkg::REG_BASE, 48'hFFFF_FFFF_FFF0);
        alloc(32'd8, 32'd0);
        write_reg(efba_pkg::REG_LIMIT, 48'hFFFF_FFFF);
        alloc(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        alloc(32'hFFFF_FFFF, 32'd0);
        alloc(32'd16, 32'd0);
        // reach the full table and its limit
        write_reg(efba_pkg::REG_BASE, 48'h0);
        write_reg(efba_pkg::REG_LIMIT, 48'hFFFF_FFFF);
        random_phase(260, 1'b0);
        for (int i = 0; i < 20; i++) alloc(32'd3 + i, 32'd1000, 1'b1);
        write_reg(efba_pkg::REG_LIMIT, 48'd100);
        random_phase(120, 1'b1);
        write_reg(efba_pkg::REG_BASE, 48'({$urandom, $urandom}));
        write_reg(efba_pkg::REG_LIMIT, 48'(efba_pkg::LIMIT_RST));
        random_phase(300, 1'b0);
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== exact_fit_block_allocator_unit.f =====
hw/rtl/efba_pkg.sv
hw/rtl/efba_table.sv
hw/rtl/efba_ctrl.sv
hw/rtl/exact_fit_block_allocator_unit.sv
tb/efba_checker.sv
tb/testbench.sv
